@@ hw/rtl/cie_pkg.sv @@
// Package with shared types and constants of the calculator instruction execute block.
package cie_pkg;

  localparam int unsigned NumRegisters = 10;
  localparam int unsigned MaxLines     = 100;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOVE = 4'd4,
    OP_CMP  = 4'd5,
    OP_JUMP = 4'd6,
    OP_BEQ  = 4'd7,
    OP_BNE  = 4'd8,
    OP_GCD  = 4'd9,
    OP_HALT = 4'd10
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIVZERO  = 3'd1,
    ST_BADREG   = 3'd2,
    ST_NOTARGET = 3'd3,
    ST_BADOP    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_DIVIDE,
    S_GCD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic        first_is_register;
    logic [31:0] first_value;
    logic        second_is_register;
    logic [31:0] second_value;
    logic [3:0]  destination_register;
    logic [6:0]  target_line;
  } req_t;

  typedef struct packed {
    logic        write_enable;
    logic [3:0]  written_register;
    logic [31:0] written_value;
    logic        branch_taken;
    logic [6:0]  next_line;
    logic        halted;
    logic [2:0]  status;
  } rsp_t;

endpackage

@@ hw/rtl/cie_if.sv @@
// Valid/ready channel interface carrying one payload.
interface cie_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/cie_divu.sv @@
// Shared radix-2 unsigned divider: one quotient bit per cycle.
module cie_divu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [31:0] quotient_o,
  output logic [31:0] remainder_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      cnt_d = 6'd32;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = (cnt_q != 6'd0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_o) else $error("divider started while busy");
  a_count_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> cnt_q == 6'd32) else $error("divider count not loaded");
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> cnt_q == $past(cnt_q) - 6'd1)
    else $error("divider count skipped");
`endif

endmodule

@@ hw/rtl/calculator_instruction_execute.sv @@
// Top level of the calculator instruction execute block.
//
// One request on req carries a decoded instruction; one response on rsp carries
// the register write, branch decision, halt flag and status it produced.
// The program_length register is written through cfg_we_i/cfg_wdata_i; the user
// must do so only while idle, which the block does not enforce. Register file:
// NumRegisters words of 32 bits, cleared by reset.
//
// An accepted request goes to the fetch state, which reads the operands. Add,
// sub, move, compare, jump, branch, halt and every error go to the done state,
// multiply through the multiply state, divide through the divide state, which
// skips the divider when the dividend is zero, and GCD through at most 46 Euclid
// steps on the shared radix-2 divider. The block takes one request at a time:
// req.ready is high only while idle, so not until the last response is taken.
//
// rst_ni clears the register file, program_length and the sequencer at once.
// The response is held in an output register; if the receiver stalls, it
// stays valid and unchanged, and no new request is taken until it is taken.
module calculator_instruction_execute #(
  parameter int unsigned NUM_REGISTERS = cie_pkg::NumRegisters,
  parameter int unsigned MAX_LINES     = cie_pkg::MaxLines
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  cie_if.sink        req,
  cie_if.source      rsp
);

  localparam int unsigned IdxW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

  cie_pkg::state_e state_q, state_d;
  cie_pkg::req_t   ins_q, ins_d;
  cie_pkg::rsp_t   out_q, out_d;

  logic [31:0] regs_q [NUM_REGISTERS];
  logic [6:0]  plen_q;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [31:0] res_q, res_d;
  logic        res_neg_q, res_neg_d;
  logic [31:0] div_a, div_b, quo, rem;
  logic        div_start, div_busy;
  logic        reg_we;
  logic [IdxW-1:0] reg_idx;
  logic [31:0] reg_val;

  // Source operands.
  logic bad_a, bad_b, bad_dst;
  logic [31:0] src_a, src_b;
  logic [IdxW-1:0] ia, ib;

  assign ia = ins_q.first_value[IdxW-1:0];
  assign ib = ins_q.second_value[IdxW-1:0];
  assign bad_a = ins_q.first_is_register && (ins_q.first_value >= 32'(NUM_REGISTERS));
  assign bad_b = ins_q.second_is_register && (ins_q.second_value >= 32'(NUM_REGISTERS));
  assign bad_dst = 32'(ins_q.destination_register) >= 32'(NUM_REGISTERS);
  assign src_a = !ins_q.first_is_register ? ins_q.first_value :
                 (bad_a ? '0 : regs_q[ia]);
  assign src_b = !ins_q.second_is_register ? ins_q.second_value :
                 (bad_b ? '0 : regs_q[ib]);

  logic [6:0] limit;
  logic       tgt_ok, r0_zero;
  assign limit   = (32'(plen_q) > 32'(MAX_LINES)) ? 7'(MAX_LINES) : plen_q;
  assign tgt_ok  = (ins_q.target_line >= 7'd1) && (ins_q.target_line <= limit);
  assign r0_zero = (regs_q[0] == 32'd0);

  // During GCD the running first operand in res_q is the dividend.
  assign div_a = (state_q == cie_pkg::S_GCD) ? res_q : a_q;
  assign div_b = b_q;

  cie_divu u_divu (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_comb begin
    logic [31:0] prod;
    state_d   = state_q;
    ins_d     = ins_q;
    out_d     = out_q;
    a_d       = a_q;
    b_d       = b_q;
    res_d     = res_q;
    res_neg_d = res_neg_q;
    div_start = 1'b0;
    reg_we    = 1'b0;
    reg_idx   = '0;
    reg_val   = res_q;
    prod      = a_q * b_q;
    case (state_q)
      cie_pkg::S_IDLE: begin
        if (req.valid) begin
          ins_d   = req.payload;
          state_d = cie_pkg::S_FETCH;
        end
      end
      cie_pkg::S_FETCH: begin
        out_d = '0;
        a_d = src_a;
        b_d = src_b;
        state_d = cie_pkg::S_DONE;
        case (ins_q.opcode)
          cie_pkg::OP_ADD, cie_pkg::OP_SUB, cie_pkg::OP_MUL, cie_pkg::OP_DIV,
          cie_pkg::OP_CMP, cie_pkg::OP_GCD: begin
            if (bad_a || bad_b) begin
              out_d.status = cie_pkg::ST_BADREG;
            end else begin
              out_d.write_enable = 1'b1;
              case (ins_q.opcode)
                cie_pkg::OP_ADD: out_d.written_value = src_a + src_b;
                cie_pkg::OP_SUB: out_d.written_value = src_a - src_b;
                cie_pkg::OP_CMP: out_d.written_value =
                  (src_a == src_b) ? 32'd0 :
                  ($signed(src_a) > $signed(src_b) ? 32'd1 : 32'hFFFF_FFFF);
                cie_pkg::OP_MUL: state_d = cie_pkg::S_MUL;
                cie_pkg::OP_DIV: begin
                  if (src_b == 32'd0) begin
                    out_d.write_enable = 1'b0;
                    out_d.status = cie_pkg::ST_DIVZERO;
                  end else begin
                    a_d = src_a[31] ? 32'd0 - src_a : src_a;
                    b_d = src_b[31] ? 32'd0 - src_b : src_b;
                    res_neg_d = src_a[31] ^ src_b[31];
                    state_d = cie_pkg::S_DIVIDE;
                  end
                end
                default: begin
                  // GCD on magnitudes; a is kept in res_q, b feeds the divider.
                  res_d = src_a[31] ? 32'd0 - src_a : src_a;
                  b_d   = src_b[31] ? 32'd0 - src_b : src_b;
                  res_neg_d = 1'b0;
                  state_d = cie_pkg::S_GCD;
                end
              endcase
            end
          end
          cie_pkg::OP_MOVE: begin
            if (bad_a || bad_dst) begin
              out_d.status = cie_pkg::ST_BADREG;
            end else begin
              out_d.write_enable = 1'b1;
              out_d.written_register = ins_q.destination_register;
              out_d.written_value = src_a;
            end
          end
          cie_pkg::OP_JUMP, cie_pkg::OP_BEQ, cie_pkg::OP_BNE: begin
            if ((ins_q.opcode == cie_pkg::OP_JUMP) ||
                (ins_q.opcode == cie_pkg::OP_BEQ && r0_zero) ||
                (ins_q.opcode == cie_pkg::OP_BNE && !r0_zero)) begin
              if (tgt_ok) begin
                out_d.branch_taken = 1'b1;
                out_d.next_line = ins_q.target_line;
              end else begin
                out_d.status = cie_pkg::ST_NOTARGET;
              end
            end
          end
          cie_pkg::OP_HALT: out_d.halted = 1'b1;
          default: out_d.status = cie_pkg::ST_BADOP;
        endcase
        if (state_d == cie_pkg::S_DONE && out_d.write_enable) begin
          reg_we  = 1'b1;
          reg_idx = out_d.written_register[IdxW-1:0];
          reg_val = out_d.written_value;
        end
      end
      cie_pkg::S_MUL: begin
        out_d.written_value = prod;
        reg_we  = 1'b1;
        reg_val = prod;
        state_d = cie_pkg::S_DONE;
      end
      cie_pkg::S_DIVIDE: begin
        if (!div_busy && a_q != 32'd0 && b_q != 32'd0 && res_q != 32'hFFFF_FFFF) begin
          div_start = 1'b1;
          res_d = 32'hFFFF_FFFF;
        end else if (!div_busy) begin
          out_d.written_value = res_neg_q ? 32'd0 - quo : quo;
          if (a_q == 32'd0) out_d.written_value = 32'd0;
          reg_we  = 1'b1;
          reg_val = out_d.written_value;
          res_d   = '0;
          state_d = cie_pkg::S_DONE;
        end
      end
      cie_pkg::S_GCD: begin
        // res_q holds a and is the divider dividend, b_q holds b; res_neg_q marks
        // a division in flight.
        if (!div_busy && res_neg_q) begin
          res_d = b_q;
          b_d   = rem;
          res_neg_d = 1'b0;
        end else if (!div_busy && b_q == 32'd0) begin
          out_d.written_value = res_q;
          reg_we  = 1'b1;
          reg_val = res_q;
          state_d = cie_pkg::S_DONE;
        end else if (!div_busy) begin
          res_neg_d = 1'b1;
          div_start = 1'b1;
        end
      end
      cie_pkg::S_DONE: begin
        if (rsp.ready) state_d = cie_pkg::S_IDLE;
      end
      default: state_d = cie_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cie_pkg::S_IDLE;
      plen_q    <= '0;
      res_neg_q <= 1'b0;
      res_q     <= '0;
      for (int i = 0; i < int'(NUM_REGISTERS); i++) regs_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      res_neg_q <= res_neg_d;
      res_q     <= res_d;
      if (cfg_we_i) plen_q <= cfg_wdata_i;
      if (reg_we) regs_q[reg_idx] <= reg_val;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    out_q <= out_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign req.ready   = (state_q == cie_pkg::S_IDLE);
  assign rsp.valid   = (state_q == cie_pkg::S_DONE);
  assign rsp.payload = out_q;

`ifndef ASSERT_OFF
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.ready && rsp.valid)) else $error("accepting while response pending");
  a_err_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.payload.status != cie_pkg::ST_OK |-> !rsp.payload.write_enable &&
    !rsp.payload.branch_taken) else $error("error with side effect");
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> state_q == cie_pkg::S_FETCH)
    else $error("accepted request not fetched");
`endif

endmodule
